[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/avc2ab_pkg.sv]
// ----------------------------------------------------------------------------
// avc2ab_pkg
// Types and constants shared by the AVC tag to Annex-B converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package avc2ab_pkg;

  localparam int TAG_SIZE_BITS = 24;
  localparam int LEN_W         = 32;

  localparam logic [3:0] AVC_CODEC_ID   = 4'h7;
  localparam logic [7:0] PKT_SEQ_HDR    = 8'h00;
  localparam logic [7:0] PKT_NALU       = 8'h01;
  localparam logic [4:0] NAL_TYPE_SPS   = 5'd7;
  localparam logic [4:0] NAL_TYPE_OTHER = 5'd5;

  localparam logic [TAG_SIZE_BITS-1:0] NALU_HDR_LAST = TAG_SIZE_BITS'(4);
  localparam logic [TAG_SIZE_BITS-1:0] CFG_LEN_POS   = TAG_SIZE_BITS'(9);
  localparam logic [TAG_SIZE_BITS-1:0] CFG_SPS_POS   = TAG_SIZE_BITS'(10);

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_TRUNC  = 2'd1,
    STATUS_NOTAVC = 2'd2
  } status_t;

  // Results caused by one input byte: an optional start code, an optional
  // stream byte and an optional end-of-tag summary, emitted in that order.
  typedef struct packed {
    logic       sc;
    logic       dat;
    logic [7:0] data_byte;
    logic       sum;
    logic [4:0] nal_type;
    logic [7:0] profile;
    logic [7:0] level;
    status_t    status;
  } res_desc_t;

endpackage

[sv/avc2ab_parse.sv]
// ----------------------------------------------------------------------------
// avc2ab_parse
// Tag body parser: holds the conversion state and works out the results of
// each accepted byte in a single pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module avc2ab_parse (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [7:0]             data_byte,
  input  logic                   is_video_tag,
  input  logic                   end_of_tag,
  output avc2ab_pkg::res_desc_t  desc
);

  typedef enum logic [11:0] {
    PH_HEAD     = 12'b0000_0000_0001,
    PH_SKIP     = 12'b0000_0000_0010,
    PH_PTYPE    = 12'b0000_0000_0100,
    PH_NHDR     = 12'b0000_0000_1000,
    PH_NPREFIX  = 12'b0000_0001_0000,
    PH_NPAY     = 12'b0000_0010_0000,
    PH_CHDR     = 12'b0000_0100_0000,
    PH_CSPSLEN  = 12'b0000_1000_0000,
    PH_CSPS     = 12'b0001_0000_0000,
    PH_CNUMPPS  = 12'b0010_0000_0000,
    PH_CPPSLEN  = 12'b0100_0000_0000,
    PH_CPPS     = 12'b1000_0000_0000
  } phase_t;

  localparam logic [avc2ab_pkg::TAG_SIZE_BITS-1:0] POS_MAX = '1;

  phase_t                                 phase_r, phase_nxt;
  logic [avc2ab_pkg::TAG_SIZE_BITS-1:0]   pos_r, pos_nxt;
  logic                                   accept_tag_r, accept_tag_nxt;
  logic [7:0]                             ptype_r, ptype_nxt;
  logic [avc2ab_pkg::LEN_W-1:0]           acc_r, acc_nxt;
  logic [2:0]                             prefix_r, prefix_nxt;
  logic [avc2ab_pkg::LEN_W-1:0]           pay_r, pay_nxt;
  logic [2:0]                             lfs_r, lfs_nxt;
  logic [7:0]                             profile_r, profile_nxt;
  logic [7:0]                             level_r, level_nxt;
  logic [4:0]                             last_nal_r, last_nal_nxt;
  logic                                   trunc_r, trunc_nxt;

  logic [avc2ab_pkg::LEN_W-1:0]           acc_shift;
  logic [avc2ab_pkg::LEN_W-1:0]           acc16;
  logic [avc2ab_pkg::LEN_W-1:0]           pay_dec;
  logic [avc2ab_pkg::LEN_W-1:0]           sps_idx;
  logic [2:0]                             prefix_dec;
  logic                                   ends_inside;

  assign acc_shift  = {acc_r[avc2ab_pkg::LEN_W-9:0], data_byte};
  assign acc16      = {16'h0000, acc_r[7:0], data_byte};
  assign pay_dec    = pay_r - avc2ab_pkg::LEN_W'(1);
  assign sps_idx    = acc_r - pay_r;
  assign prefix_dec = (prefix_r != 3'd0) ? (prefix_r - 3'd1) : 3'd0;

  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_r;
    accept_tag_nxt = accept_tag_r;
    ptype_nxt      = ptype_r;
    acc_nxt        = acc_r;
    prefix_nxt     = prefix_r;
    pay_nxt        = pay_r;
    lfs_nxt        = lfs_r;
    profile_nxt    = profile_r;
    level_nxt      = level_r;
    last_nal_nxt   = last_nal_r;
    trunc_nxt      = trunc_r;
    ends_inside    = 1'b0;
    desc           = '0;
    desc.data_byte = data_byte;

    unique case (phase_r)
      PH_HEAD: begin
        accept_tag_nxt = is_video_tag && (data_byte[3:0] == avc2ab_pkg::AVC_CODEC_ID);
        ptype_nxt      = 8'h00;
        last_nal_nxt   = 5'd0;
        trunc_nxt      = 1'b0;
        phase_nxt      = accept_tag_nxt ? PH_PTYPE : PH_SKIP;
      end
      PH_PTYPE: begin
        ptype_nxt = data_byte;
        if (data_byte == avc2ab_pkg::PKT_NALU) begin
          phase_nxt = PH_NHDR;
        end else if (data_byte == avc2ab_pkg::PKT_SEQ_HDR) begin
          phase_nxt = PH_CHDR;
        end else begin
          phase_nxt = PH_SKIP;
        end
      end
      PH_NHDR: begin
        if (pos_r >= avc2ab_pkg::NALU_HDR_LAST) begin
          acc_nxt    = '0;
          prefix_nxt = lfs_r;
          phase_nxt  = PH_NPREFIX;
        end
      end
      PH_NPREFIX: begin
        acc_nxt    = acc_shift;
        prefix_nxt = prefix_dec;
        if (prefix_dec == 3'd0) begin
          desc.sc = 1'b1;
          pay_nxt = acc_shift;
          if (acc_shift == '0) begin
            acc_nxt    = '0;
            prefix_nxt = lfs_r;
          end else begin
            phase_nxt = PH_NPAY;
          end
        end
      end
      PH_NPAY: begin
        if (pay_r == acc_r) begin
          last_nal_nxt = data_byte[4:0];
        end
        desc.dat = 1'b1;
        pay_nxt  = pay_dec;
        if (pay_dec == '0) begin
          acc_nxt    = '0;
          prefix_nxt = lfs_r;
          phase_nxt  = PH_NPREFIX;
        end
      end
      PH_CHDR: begin
        if (pos_r == avc2ab_pkg::CFG_LEN_POS) begin
          lfs_nxt = {1'b0, data_byte[1:0]} + 3'd1;
        end
        if (pos_r >= avc2ab_pkg::CFG_SPS_POS) begin
          acc_nxt    = '0;
          prefix_nxt = 3'd2;
          phase_nxt  = PH_CSPSLEN;
        end
      end
      PH_CSPSLEN, PH_CPPSLEN: begin
        acc_nxt    = acc16;
        prefix_nxt = prefix_dec;
        if (prefix_dec == 3'd0) begin
          desc.sc = 1'b1;
          pay_nxt = acc16;
          if (phase_r == PH_CSPSLEN) begin
            phase_nxt = (acc16 != '0) ? PH_CSPS : PH_CNUMPPS;
          end else begin
            phase_nxt = (acc16 != '0) ? PH_CPPS : PH_SKIP;
          end
        end
      end
      PH_CSPS: begin
        if (sps_idx == avc2ab_pkg::LEN_W'(0)) begin
          last_nal_nxt = data_byte[4:0];
        end
        if (sps_idx == avc2ab_pkg::LEN_W'(1) && last_nal_r == avc2ab_pkg::NAL_TYPE_SPS) begin
          profile_nxt = data_byte;
        end
        if (sps_idx == avc2ab_pkg::LEN_W'(3) && last_nal_r == avc2ab_pkg::NAL_TYPE_SPS) begin
          level_nxt = data_byte;
        end
        desc.dat = 1'b1;
        pay_nxt  = pay_dec;
        if (pay_dec == '0) begin
          phase_nxt = PH_CNUMPPS;
        end
      end
      PH_CNUMPPS: begin
        acc_nxt    = '0;
        prefix_nxt = 3'd2;
        phase_nxt  = PH_CPPSLEN;
      end
      PH_CPPS: begin
        if (pay_r == acc_r) begin
          last_nal_nxt = data_byte[4:0];
        end
        desc.dat = 1'b1;
        pay_nxt  = pay_dec;
        if (pay_dec == '0) begin
          phase_nxt = PH_SKIP;
        end
      end
      PH_SKIP: begin
        phase_nxt = PH_SKIP;
      end
      default: begin
        phase_nxt = PH_SKIP;
      end
    endcase

    if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + avc2ab_pkg::TAG_SIZE_BITS'(1);
    end

    if (end_of_tag) begin
      ends_inside = (phase_nxt == PH_PTYPE)   || (phase_nxt == PH_NPAY)    ||
                    (phase_nxt == PH_CHDR)    || (phase_nxt == PH_CSPSLEN) ||
                    (phase_nxt == PH_CSPS)    || (phase_nxt == PH_CNUMPPS) ||
                    (phase_nxt == PH_CPPSLEN) || (phase_nxt == PH_CPPS)    ||
                    ((phase_nxt == PH_NPREFIX) && (prefix_nxt != lfs_nxt));
      if (ends_inside) begin
        trunc_nxt = 1'b1;
      end
      desc.sum     = 1'b1;
      desc.profile = profile_nxt;
      desc.level   = level_nxt;
      if (!accept_tag_nxt) begin
        desc.status = avc2ab_pkg::STATUS_NOTAVC;
      end else if (trunc_nxt) begin
        desc.status = avc2ab_pkg::STATUS_TRUNC;
      end else begin
        desc.status = avc2ab_pkg::STATUS_OK;
      end
      if (accept_tag_nxt && ptype_nxt != avc2ab_pkg::PKT_SEQ_HDR &&
          ptype_nxt != avc2ab_pkg::PKT_NALU) begin
        desc.nal_type = avc2ab_pkg::NAL_TYPE_OTHER;
      end else begin
        desc.nal_type = last_nal_nxt;
      end
      phase_nxt = PH_HEAD;
      pos_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEAD;
      pos_r        <= '0;
      accept_tag_r <= 1'b0;
      ptype_r      <= 8'h00;
      acc_r        <= '0;
      prefix_r     <= 3'd0;
      pay_r        <= '0;
      lfs_r        <= 3'd4;
      profile_r    <= 8'h00;
      level_r      <= 8'h00;
      last_nal_r   <= 5'd0;
      trunc_r      <= 1'b0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      accept_tag_r <= accept_tag_nxt;
      ptype_r      <= ptype_nxt;
      acc_r        <= acc_nxt;
      prefix_r     <= prefix_nxt;
      pay_r        <= pay_nxt;
      lfs_r        <= lfs_nxt;
      profile_r    <= profile_nxt;
      level_r      <= level_nxt;
      last_nal_r   <= last_nal_nxt;
      trunc_r      <= trunc_nxt;
    end
  end

endmodule

[sv/avc2ab_emit.sv]
// ----------------------------------------------------------------------------
// avc2ab_emit
// Result register: holds the results of one byte and hands them out one per
// cycle while out_ready is high: start code, then stream byte, then summary.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module avc2ab_emit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  avc2ab_pkg::res_desc_t desc,
  output logic                  can_load,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_kind,
  output logic [7:0]            out_byte,
  output logic [4:0]            out_nal_type,
  output logic [7:0]            out_profile,
  output logic [7:0]            out_level,
  output logic [1:0]            out_status
);

  logic [2:0]          sc_cnt_r, sc_cnt_nxt;
  logic                dat_r, dat_nxt;
  logic                sum_r, sum_nxt;
  logic [7:0]          byte_r;
  logic [4:0]          nal_r;
  logic [7:0]          profile_r;
  logic [7:0]          level_r;
  avc2ab_pkg::status_t status_r;
  logic                single;
  logic                take;
  logic                in_sc;

  assign in_sc     = (sc_cnt_r != 3'd0);
  assign out_valid = in_sc || dat_r || sum_r;
  assign single    = ((sc_cnt_r == 3'd1) && !dat_r && !sum_r) ||
                     (!in_sc && (dat_r ^ sum_r));
  assign take      = out_valid && out_ready;
  assign can_load  = !out_valid || (single && out_ready);

  always_comb begin
    out_kind     = 1'b0;
    out_byte     = 8'h00;
    out_nal_type = 5'd0;
    out_profile  = 8'h00;
    out_level    = 8'h00;
    out_status   = avc2ab_pkg::STATUS_OK;
    if (in_sc) begin
      out_byte = (sc_cnt_r == 3'd1) ? 8'h01 : 8'h00;
    end else if (dat_r) begin
      out_byte = byte_r;
    end else if (sum_r) begin
      out_kind     = 1'b1;
      out_nal_type = nal_r;
      out_profile  = profile_r;
      out_level    = level_r;
      out_status   = status_r;
    end
  end

  always_comb begin
    sc_cnt_nxt = sc_cnt_r;
    dat_nxt    = dat_r;
    sum_nxt    = sum_r;
    if (load) begin
      sc_cnt_nxt = desc.sc ? 3'd4 : 3'd0;
      dat_nxt    = desc.dat;
      sum_nxt    = desc.sum;
    end else if (take) begin
      if (in_sc) begin
        sc_cnt_nxt = sc_cnt_r - 3'd1;
      end else if (dat_r) begin
        dat_nxt = 1'b0;
      end else begin
        sum_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_cnt_r <= 3'd0;
      dat_r    <= 1'b0;
      sum_r    <= 1'b0;
    end else begin
      sc_cnt_r <= sc_cnt_nxt;
      dat_r    <= dat_nxt;
      sum_r    <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r    <= desc.data_byte;
      nal_r     <= desc.nal_type;
      profile_r <= desc.profile;
      level_r   <= desc.level;
      status_r  <= desc.status;
    end
  end

endmodule

[sv/flv_avc_tag_to_annexb.sv]
// ----------------------------------------------------------------------------
// flv_avc_tag_to_annexb
// Converts the body bytes of AVC video tags into an Annex-B byte stream and
// closes every tag with a summary transaction.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata                                          tuser         tlast
// in_      in   data_byte[7:0]                                 is_video_tag  end_of_tag
// out_     out  out_byte, nal_type, profile, level, status     kind          last
//
// A byte yields up to five output transactions: a length prefix end gives a
// four-byte start code, a payload byte gives one byte, and the final byte of a
// tag adds a summary. The single output port moves one transaction per cycle
// while out_tready is high; payload bytes also stream at one per cycle.
// Reset is synchronous and active low. Input is taken while the result
// register is empty or is handing out its last pending transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module flv_avc_tag_to_annexb (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] is_video_tag
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] out_byte, [12:8] nal_type, [20:13] profile,
                                  // [28:21] level, [30:29] status, [31] zero
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast
);

  avc2ab_pkg::res_desc_t desc;
  logic                  accept;
  logic                  can_load;
  logic [7:0]            o_byte;
  logic [4:0]            o_nal;
  logic [7:0]            o_profile;
  logic [7:0]            o_level;
  logic [1:0]            o_status;
  logic                  o_kind;

  assign in_tready = can_load;
  assign accept    = in_tvalid && can_load;

  avc2ab_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .data_byte    (in_tdata),
    .is_video_tag (in_tuser),
    .end_of_tag   (in_tlast),
    .desc         (desc)
  );

  avc2ab_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (accept),
    .desc         (desc),
    .can_load     (can_load),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_kind     (o_kind),
    .out_byte     (o_byte),
    .out_nal_type (o_nal),
    .out_profile  (o_profile),
    .out_level    (o_level),
    .out_status   (o_status)
  );

  assign out_tdata = {1'b0, o_status, o_level, o_profile, o_nal, o_byte};
  assign out_tuser = o_kind;
  assign out_tlast = o_kind;

  `ASSERT_SAME(a_empty_takes_input, clk, rst_n, !out_tvalid, in_tready,
               "Empty result register must accept input.")
  `ASSERT_NEXT(a_tag_end_gives_result, clk, rst_n, in_tvalid && in_tready && in_tlast,
               out_tvalid, "Final tag byte must produce a pending result.")
  `ASSERT_SAME(a_stream_byte_clean, clk, rst_n, out_tvalid && !out_tuser,
               out_tdata[31:8] == 24'h000000, "Stream byte carries summary fields.")
  `ASSERT_SAME(a_summary_byte_zero, clk, rst_n, out_tvalid && out_tuser,
               out_tdata[7:0] == 8'h00 && out_tdata[30:29] != 2'd3,
               "Summary carries a stream byte or a bad status.")

endmodule
